[design/chs_pkg.sv]
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants and the arctangent table of the hemisphere sampler.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int RATIO_W = 31;     // ratio in Q1.30, at most one
    localparam int THETA_W = 30;     // angle magnitude, Q0.30, at most pi/4
    localparam int CX_W    = 33;     // CORDIC x/y datapath
    localparam int CZ_W    = 32;     // CORDIC residual angle

    localparam logic [29:0] PI4_Q30      = 30'd843314857;
    localparam logic [31:0] CORDIC_K_Q30 = 32'd652032874;
    localparam logic [31:0] Q30_ONE      = 32'd1073741824;

    // atan(2^-i) in Q30
    function automatic logic [31:0] atan_q30(input int unsigned i);
        logic [31:0] t;
        case (i)
            0:       t = 32'd843314857;
            1:       t = 32'd497837829;
            2:       t = 32'd263043837;
            3:       t = 32'd133525159;
            4:       t = 32'd67021687;
            5:       t = 32'd33543516;
            6:       t = 32'd16775851;
            7:       t = 32'd8388437;
            8:       t = 32'd4194283;
            9:       t = 32'd2097149;
            default: t = (i <= 30) ? (Q30_ONE >> i) : 32'd0;
        endcase
        return t;
    endfunction

endpackage

[design/cosine_hemisphere_sampler_unit.sv]
// ----------------------------------------------------------------------------
// cosine_hemisphere_sampler_unit
// Cosine-weighted hemisphere direction from a 2D uniform sample.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one transfer carries a 2D sample (u, v), Q0.16 each.
//   Master channel m_*: one transfer per sample carries a direction with
//   x, y in signed Q1.15 and z in Q0.15 (never zero).
//   The sample is folded onto the unit disk with the concentric map: a
//   restoring divider forms the coordinate ratio one bit per stage, a
//   multiplier scales it to an angle, a CORDIC stage per step gives sine
//   and cosine, the radius scales them, and a bit-per-stage square root
//   gives z from the disk point.
//   Pipeline: between input transfer and output lie the 31 divider
//   stages, the CORDIC stages and the 16 square-root stages.
//   Throughput: one transfer per cycle while the output is not stalled;
//   every stage is a register.
//   Stall: the whole pipeline holds while a result waits on m_tready;
//   s_tready drops in the same cycle, so nothing is lost or repeated.
//   Bubbles advance whenever the output register is empty or taken.
//   Reset: aresetn low clears all valid bits; the unit is ready at once.
// ----------------------------------------------------------------------------
module cosine_hemisphere_sampler_unit #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sample_u, [31:16] sample_v
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [15:0] dir_x, [31:16] dir_y, [46:32] dir_z, [47] zero
);
    localparam int SB     = SAMPLE_BITS;
    localparam int SIDE_W = SB + 4;
    localparam int RW     = chs_pkg::RATIO_W;
    localparam int TW     = chs_pkg::THETA_W;
    localparam int XW     = chs_pkg::CX_W;
    localparam int SQ_N   = 16;

    // side vector layout: big magnitude, first branch, radius negative,
    // angle negative, zero sample
    localparam int SD_ZERO  = 0;
    localparam int SD_TNEG  = 1;
    localparam int SD_RNEG  = 2;
    localparam int SD_FIRST = 3;
    localparam int SD_BIG   = 4;

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > 21'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -21'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 0: center the sample, pick the radius
    logic [SB-1:0] su, sv;
    if (SB <= 16) begin : g_narrow
        assign su = s_tdata[SB-1:0];
        assign sv = s_tdata[16+SB-1:16];
    end else begin : g_wide
        assign su = {{(SB-16){1'b0}}, s_tdata[15:0]};
        assign sv = {{(SB-16){1'b0}}, s_tdata[31:16]};
    end

    logic [SB:0]   half;
    logic [SB:0]   a, b, na, nb;
    logic [SB-1:0] ma, mb;
    logic          first;
    assign half  = (SB+1)'(1) << (SB - 1);
    assign a     = {1'b0, su} - half;
    assign b     = {1'b0, sv} - half;
    assign na    = -a;
    assign nb    = -b;
    assign ma    = a[SB] ? na[SB-1:0] : a[SB-1:0];
    assign mb    = b[SB] ? nb[SB-1:0] : b[SB-1:0];
    assign first = ma > mb;

    logic              in_valid_reg;
    logic [SB-1:0]     big_reg, small_reg;
    logic [SIDE_W-1:0] side0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big_reg   <= first ? ma : mb;
            small_reg <= first ? mb : ma;
            side0_reg <= {first ? ma : mb, first, first ? a[SB] : b[SB],
                          a[SB] ^ b[SB], (ma == '0) && (mb == '0)};
        end
    end

    // ---------------- ratio = small / big in Q1.30
    logic              div_valid;
    logic [RW-1:0]     div_quot;
    logic [SIDE_W-1:0] div_side;

    chs_divider #(.MAG_W(SB), .SIDE_W(SIDE_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_num    (small_reg),
        .in_den    (big_reg),
        .in_side   (side0_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // ---------------- angle = ratio * pi/4, rounded
    logic [61:0]       th_full;
    logic              th_valid_reg;
    logic [TW-1:0]     theta_reg;
    logic [SIDE_W-1:0] th_side_reg;
    assign th_full = {31'b0, div_quot} * {32'b0, chs_pkg::PI4_Q30} + (62'd1 << 29);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            th_valid_reg <= 1'b0;
        end else if (en) begin
            th_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            theta_reg   <= th_full[59:30];
            th_side_reg <= div_side;
        end
    end

    // ---------------- sine and cosine
    logic                 cor_valid;
    logic signed [XW-1:0] cor_cos, cor_sin;
    logic [SIDE_W-1:0]    cor_side;

    chs_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(SIDE_W)) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (th_valid_reg),
        .in_theta  (theta_reg),
        .in_side   (th_side_reg),
        .out_valid (cor_valid),
        .out_cos   (cor_cos),
        .out_sin   (cor_sin),
        .out_side  (cor_side)
    );

    // ---------------- scale by the signed radius
    logic [SB-1:0]        big_c;
    logic [30:0]          rmag;
    logic signed [XW-1:0] r, sy, cphi, sphi;
    assign big_c = cor_side[SD_BIG +: SB];
    if (SB <= 31) begin : g_rq30
        if (SB == 31) begin : g_eq
            assign rmag = big_c;
        end else begin : g_sh
            assign rmag = {big_c, {(31-SB){1'b0}}};
        end
    end else begin : g_rdrop
        assign rmag = big_c[31:1];
    end
    assign r    = cor_side[SD_RNEG] ? -$signed({2'b0, rmag}) : $signed({2'b0, rmag});
    assign sy   = cor_side[SD_TNEG] ? -cor_sin : cor_sin;
    assign cphi = cor_side[SD_FIRST] ? cor_cos : sy;
    assign sphi = cor_side[SD_FIRST] ? sy : cor_cos;

    logic                    px_valid_reg, px_zero_reg;
    logic signed [2*XW-1:0]  px_reg, py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_valid_reg <= 1'b0;
        end else if (en) begin
            px_valid_reg <= cor_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg      <= r * cphi;
            py_reg      <= r * sphi;
            px_zero_reg <= cor_side[SD_ZERO];
        end
    end

    // ---------------- round to Q1.15 and saturate
    logic signed [2*XW-1:0] xsum, ysum, xsh, ysh;
    assign xsum = px_reg + ((2*XW)'(1) <<< 44);
    assign ysum = py_reg + ((2*XW)'(1) <<< 44);
    assign xsh  = xsum >>> 45;
    assign ysh  = ysum >>> 45;

    logic               xy_valid_reg;
    logic signed [15:0] x_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xy_valid_reg <= 1'b0;
        end else if (en) begin
            xy_valid_reg <= px_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= px_zero_reg ? 16'sd0 : sat16(xsh[20:0]);
            y_reg <= px_zero_reg ? 16'sd0 : sat16(ysh[20:0]);
        end
    end

    // ---------------- squares
    logic               sq_valid_reg;
    logic signed [31:0] xx_reg, yy_reg;
    logic signed [15:0] x2_reg, y2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (en) begin
            sq_valid_reg <= xy_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            x2_reg <= x_reg;
            y2_reg <= y_reg;
        end
    end

    // ---------------- d = 1 - x^2 - y^2, clamped at zero
    logic signed [33:0] d;
    assign d = $signed({2'b0, chs_pkg::Q30_ONE}) - 34'(xx_reg) - 34'(yy_reg);

    logic               d_valid_reg;
    logic [30:0]        d_reg;
    logic signed [15:0] x3_reg, y3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg  <= (d > 34'sd0) ? d[30:0] : 31'd0;
            x3_reg <= x2_reg;
            y3_reg <= y2_reg;
        end
    end

    // ---------------- square root, one result bit per stage
    logic               rt_valid_reg [SQ_N];
    logic [15:0]        root_reg     [SQ_N];
    logic [30:0]        rd_reg       [SQ_N];
    logic signed [15:0] rx_reg       [SQ_N];
    logic signed [15:0] ry_reg       [SQ_N];

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic               v_in;
        logic [15:0]        root_in, trial;
        logic [30:0]        d_in;
        logic signed [15:0] x_in, y_in;
        logic [31:0]        tsq;

        if (k == 0) begin : g_first
            assign v_in    = d_valid_reg;
            assign root_in = '0;
            assign d_in    = d_reg;
            assign x_in    = x3_reg;
            assign y_in    = y3_reg;
        end else begin : g_next
            assign v_in    = rt_valid_reg[k-1];
            assign root_in = root_reg[k-1];
            assign d_in    = rd_reg[k-1];
            assign x_in    = rx_reg[k-1];
            assign y_in    = ry_reg[k-1];
        end

        assign trial = root_in | (16'h8000 >> k);
        assign tsq   = trial * trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_valid_reg[k] <= 1'b0;
            end else if (en) begin
                rt_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= (tsq <= {1'b0, d_in}) ? trial : root_in;
                rd_reg[k]   <= d_in;
                rx_reg[k]   <= x_in;
                ry_reg[k]   <= y_in;
            end
        end
    end

    // ---------------- output register
    logic [15:0] root_f;
    logic [14:0] z_sat;
    assign root_f = root_reg[SQ_N-1];
    assign z_sat  = root_f[15] ? 15'h7fff : root_f[14:0];

    logic        m_valid_reg;
    logic [15:0] ox_reg, oy_reg;
    logic [14:0] oz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= rt_valid_reg[SQ_N-1];
        end
    end

    // hold the payload while the receiver stalls
    always_ff @(posedge aclk) begin
        if (en) begin
            ox_reg <= rx_reg[SQ_N-1];
            oy_reg <= ry_reg[SQ_N-1];
            oz_reg <= (z_sat == 15'd0) ? 15'd1 : z_sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, oz_reg, oy_reg, ox_reg};

`ifndef NO_ASSERTIONS
    a_z_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[46:32] != 15'd0))
        else $error("dir_z is zero");

    a_pole: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:0] == 16'd0 && m_tdata[31:16] == 16'd0)
        |-> (m_tdata[46:32] == 15'h7fff))
        else $error("zero disk point without full z");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

[design/chs_divider.sv]
// ----------------------------------------------------------------------------
// chs_divider
// Pipelined restoring divider: one quotient bit per stage, Q1.30 ratio.
// ----------------------------------------------------------------------------
module chs_divider #(
    parameter int MAG_W  = 16,
    parameter int SIDE_W = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [MAG_W-1:0]             in_num,
    input  logic [MAG_W-1:0]             in_den,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [chs_pkg::RATIO_W-1:0]  out_quot,
    output logic [SIDE_W-1:0]            out_side
);
    localparam int RW = chs_pkg::RATIO_W;

    logic              valid_reg [RW];
    logic [MAG_W:0]    rem_reg   [RW];
    logic [MAG_W-1:0]  den_reg   [RW];
    logic [RW-1:0]     quot_reg  [RW];
    logic [SIDE_W-1:0] side_reg  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic              v_in;
        logic [MAG_W:0]    rem_in;
        logic [MAG_W:0]    trial;
        logic [MAG_W-1:0]  den_in;
        logic [RW-1:0]     q_in;
        logic [SIDE_W-1:0] side_in;
        logic              ge;

        if (k == 0) begin : g_first
            // the numerator never exceeds the denominator: no shift on the top bit
            assign v_in    = in_valid;
            assign rem_in  = {1'b0, in_num};
            assign trial   = rem_in;
            assign den_in  = in_den;
            assign q_in    = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign trial   = {rem_in[MAG_W-1:0], 1'b0};
            assign den_in  = den_reg[k-1];
            assign q_in    = quot_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign ge = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? (trial - {1'b0, den_in}) : trial;
                den_reg[k]  <= den_in;
                quot_reg[k] <= {q_in[RW-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_quot  = quot_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

[design/chs_cordic.sv]
// ----------------------------------------------------------------------------
// chs_cordic
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module chs_cordic #(
    parameter int STEPS  = 16,
    parameter int SIDE_W = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [chs_pkg::THETA_W-1:0]       in_theta,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic signed [chs_pkg::CX_W-1:0]   out_cos,
    output logic signed [chs_pkg::CX_W-1:0]   out_sin,
    output logic [SIDE_W-1:0]                 out_side
);
    localparam int XW = chs_pkg::CX_W;
    localparam int ZW = chs_pkg::CZ_W;

    logic                valid_reg [STEPS];
    logic signed [XW-1:0] cx_reg   [STEPS];
    logic signed [XW-1:0] cy_reg   [STEPS];
    logic signed [ZW-1:0] cz_reg   [STEPS];
    logic [SIDE_W-1:0]    side_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic                 v_in;
        logic signed [XW-1:0] cx_in;
        logic signed [XW-1:0] cy_in;
        logic signed [ZW-1:0] cz_in;
        logic [SIDE_W-1:0]    side_in;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] ang;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign cx_in   = $signed(XW'(chs_pkg::CORDIC_K_Q30));
            assign cy_in   = '0;
            assign cz_in   = $signed(ZW'(in_theta));
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[i-1];
            assign cx_in   = cx_reg[i-1];
            assign cy_in   = cy_reg[i-1];
            assign cz_in   = cz_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign dx  = cy_in >>> i;
        assign dy  = cx_in >>> i;
        assign ang = $signed(chs_pkg::atan_q30(i));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                // rotate toward a zero residual angle
                if (!cz_in[ZW-1]) begin
                    cx_reg[i] <= cx_in - dx;
                    cy_reg[i] <= cy_in + dy;
                    cz_reg[i] <= cz_in - ang;
                end else begin
                    cx_reg[i] <= cx_in + dx;
                    cy_reg[i] <= cy_in - dy;
                    cz_reg[i] <= cz_in + ang;
                end
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_cos   = cx_reg[STEPS-1];
    assign out_sin   = cy_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
